### src/xcpf_pkg.sv
package xcpf_pkg;

    localparam int MAX_PAYLOAD  = 1024;
    localparam int HEADER_BYTES = 13;
    localparam int FOOTER_BYTES = 1;

    localparam logic [7:0] SYNC_BYTE    = 8'h11;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] PAD_BYTE     = 8'h00;

    // header offsets
    localparam int SYNC_END     = 3;
    localparam int PKT_SIZE_END = 7;
    localparam int PAY_SIZE_END = 11;
    localparam int TAG_POS      = 11;
    localparam int XOR_POS      = 12;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_EMITTED  = 2'd1,
        ST_REFUSED  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_PULL = 1'b1
    } t_op;

    typedef enum logic {
        REG_TAG = 1'b0,
        REG_PAD = 1'b1
    } t_reg;

endpackage

### src/xcpf_if.sv
interface xcpf_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] payload_byte;
    logic       payload_last;

    modport source (output valid, output operation, output payload_byte,
                    output payload_last, input ready);
    modport sink   (input valid, input operation, input payload_byte,
                    input payload_last, output ready);
endinterface

interface xcpf_rsp_if;
    logic              valid;
    logic              ready;
    xcpf_pkg::t_status status;
    logic [7:0]        packet_byte;
    logic              end_of_packet;

    modport source (output valid, output status, output packet_byte,
                    output end_of_packet, input ready);
    modport sink   (input valid, input status, input packet_byte,
                    input end_of_packet, output ready);
endinterface

### src/xcpf_ram.sv
module xcpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = xcpf_pkg::MAX_PAYLOAD,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/xor_checked_packet_framer.sv
// Push request: result registered the cycle after acceptance, one push a cycle
// unless the output is held back. Last push with a non-zero pad unit: S_DIV,
// one remainder bit per cycle through one compare/subtract unit. Pull of a ready
// frame: S_FETCH while the payload RAM read is registered, then the byte goes to
// the output register. Not ready in S_DIV or S_FETCH. Sync reset clears counters,
// checksum, flags and registers; the payload RAM is not cleared.
module xor_checked_packet_framer #(
    parameter int MAX_PAYLOAD = xcpf_pkg::MAX_PAYLOAD
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    xcpf_req_if.sink                    i_req,
    xcpf_rsp_if.source                  o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [xcpf_pkg::APB_AW-1:0] paddr,
    input  logic [xcpf_pkg::APB_DW-1:0] pwdata,
    output logic [xcpf_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int OVH      = xcpf_pkg::HEADER_BYTES + xcpf_pkg::FOOTER_BYTES;
    localparam int CNT_W    = $clog2(MAX_PAYLOAD + 1);
    localparam int AW       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int BASE_MAX = MAX_PAYLOAD + OVH;
    localparam int BASE_W   = $clog2(BASE_MAX + 1);
    localparam int FL_W     = $clog2(BASE_MAX + 256);
    localparam int STEP_W   = $clog2(BASE_W + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FETCH
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [7:0]        r_xor, n_xor;
    logic [FL_W-1:0]   r_frame_len, n_frame_len;
    logic [FL_W-1:0]   r_emit_pos, n_emit_pos;
    logic              r_frame_rdy, n_frame_rdy;
    logic [7:0]        r_tag, n_tag;
    logic [7:0]        r_pad, n_pad;
    logic [7:0]        r_div, n_div;
    logic [BASE_W-1:0] r_dsh, n_dsh;
    logic [7:0]        r_rem, n_rem;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    xcpf_pkg::t_status r_out_status, n_out_status;
    logic [7:0]        r_out_byte, n_out_byte;
    logic              r_out_eop, n_out_eop;

    logic              accept;
    logic              cfg_wr;
    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;
    logic [FL_W-1:0]   pos_off;
    logic [31:0]       fl32;
    logic [31:0]       cnt32;
    logic [1:0]        fl_k;
    logic [1:0]        cnt_k;
    logic [7:0]        emit_byte;
    logic              at_end;
    logic [8:0]        rem_sh;
    logic [7:0]        rem_nx;

    assign accept = i_req.valid && i_req.ready;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        unique case (xcpf_pkg::t_reg'(paddr[2]))
            xcpf_pkg::REG_TAG: prdata = 32'(r_tag);
            xcpf_pkg::REG_PAD: prdata = 32'(r_pad);
            default:           prdata = '0;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.packet_byte   = r_out_byte;
    assign o_rsp.end_of_packet = r_out_eop;

    assign ram_we    = accept && (xcpf_pkg::t_op'(i_req.operation) == xcpf_pkg::OP_PUSH)
                       && !r_frame_rdy && (r_count != CNT_W'(MAX_PAYLOAD));
    assign pos_off   = r_emit_pos - FL_W'(xcpf_pkg::HEADER_BYTES);
    assign ram_raddr = pos_off[AW-1:0];

    xcpf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_req.payload_byte),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign fl32   = 32'(r_frame_len);
    assign cnt32  = 32'(r_count);
    assign fl_k   = 2'(r_emit_pos - FL_W'(xcpf_pkg::SYNC_END));
    assign cnt_k  = 2'(r_emit_pos - FL_W'(xcpf_pkg::PKT_SIZE_END));
    assign at_end = (r_emit_pos == r_frame_len - FL_W'(1));

    always_comb begin
        if (at_end) begin
            emit_byte = xcpf_pkg::NEWLINE_BYTE;
        end else if (r_emit_pos < FL_W'(xcpf_pkg::SYNC_END)) begin
            emit_byte = xcpf_pkg::SYNC_BYTE;
        end else if (r_emit_pos < FL_W'(xcpf_pkg::PKT_SIZE_END)) begin
            emit_byte = fl32[8*fl_k +: 8];
        end else if (r_emit_pos < FL_W'(xcpf_pkg::PAY_SIZE_END)) begin
            emit_byte = cnt32[8*cnt_k +: 8];
        end else if (r_emit_pos == FL_W'(xcpf_pkg::TAG_POS)) begin
            emit_byte = r_tag;
        end else if (r_emit_pos == FL_W'(xcpf_pkg::XOR_POS)) begin
            emit_byte = r_xor;
        end else if (pos_off < FL_W'(r_count)) begin
            emit_byte = ram_rdata;
        end else begin
            emit_byte = xcpf_pkg::PAD_BYTE;
        end
    end

    // remainder step of S_DIV
    assign rem_sh = {r_rem, r_dsh[BASE_W-1]};
    assign rem_nx = (rem_sh >= {1'b0, r_div}) ? 8'(rem_sh - {1'b0, r_div}) : rem_sh[7:0];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_xor        = r_xor;
        n_frame_len  = r_frame_len;
        n_emit_pos   = r_emit_pos;
        n_frame_rdy  = r_frame_rdy;
        n_tag        = r_tag;
        n_pad        = r_pad;
        n_div        = r_div;
        n_dsh        = r_dsh;
        n_rem        = r_rem;
        n_step       = r_step;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_byte   = r_out_byte;
        n_out_eop    = r_out_eop;

        if (cfg_wr) begin
            unique case (xcpf_pkg::t_reg'(paddr[2]))
                xcpf_pkg::REG_TAG: n_tag = pwdata[7:0];
                xcpf_pkg::REG_PAD: n_pad = pwdata[7:0];
                default:           n_tag = r_tag;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_byte = xcpf_pkg::PAD_BYTE;
                    n_out_eop  = 1'b0;
                    if (xcpf_pkg::t_op'(i_req.operation) == xcpf_pkg::OP_PUSH) begin
                        n_out_valid = 1'b1;
                        if (ram_we) begin
                            n_out_status = xcpf_pkg::ST_ACCEPTED;
                            n_xor        = r_xor ^ i_req.payload_byte;
                            n_count      = r_count + CNT_W'(1);
                            if (i_req.payload_last) begin
                                n_frame_len = FL_W'(r_count) + FL_W'(OVH + 1);
                                n_emit_pos  = '0;
                                n_frame_rdy = 1'b1;
                                if (r_pad != 8'd0) begin
                                    n_div   = r_pad;
                                    n_dsh   = BASE_W'(r_count) + BASE_W'(OVH + 1);
                                    n_rem   = '0;
                                    n_step  = STEP_W'(BASE_W);
                                    n_state = S_DIV;
                                end
                            end
                        end else begin
                            n_out_status = xcpf_pkg::ST_REFUSED;
                        end
                    end else if (r_frame_rdy) begin
                        n_state = S_FETCH;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_status = xcpf_pkg::ST_EMPTY;
                    end
                end
            end
            S_DIV: begin
                n_rem  = rem_nx;
                n_dsh  = r_dsh << 1;
                n_step = r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    // (floor(b/u)+1)*u == b - (b mod u) + u
                    n_frame_len = r_frame_len + FL_W'(r_div) - FL_W'(rem_nx);
                    n_state     = S_IDLE;
                end
            end
            S_FETCH: begin
                n_out_valid  = 1'b1;
                n_out_status = xcpf_pkg::ST_EMITTED;
                n_out_byte   = emit_byte;
                n_out_eop    = at_end;
                if (at_end) begin
                    n_frame_rdy = 1'b0;
                    n_count     = '0;
                    n_xor       = '0;
                    n_emit_pos  = '0;
                end else begin
                    n_emit_pos = r_emit_pos + FL_W'(1);
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_xor       <= '0;
            r_frame_len <= '0;
            r_emit_pos  <= '0;
            r_frame_rdy <= 1'b0;
            r_tag       <= '0;
            r_pad       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_xor       <= n_xor;
            r_frame_len <= n_frame_len;
            r_emit_pos  <= n_emit_pos;
            r_frame_rdy <= n_frame_rdy;
            r_tag       <= n_tag;
            r_pad       <= n_pad;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        r_div        <= n_div;
        r_dsh        <= n_dsh;
        r_rem        <= n_rem;
        r_out_status <= n_out_status;
        r_out_byte   <= n_out_byte;
        r_out_eop    <= n_out_eop;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PAYLOAD))
        else $error("payload count beyond buffer");

    a_emit_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_rdy |-> r_emit_pos < r_frame_len)
        else $error("emit position past frame end");

    a_frame_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frame_rdy && r_state == S_IDLE)
        |-> r_frame_len >= FL_W'(r_count) + FL_W'(OVH))
        else $error("frame shorter than payload and overhead");

    a_eop_emitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_eop) |-> r_out_status == xcpf_pkg::ST_EMITTED)
        else $error("end of packet without emitted byte");

    a_fetch_from_pull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |-> $past(accept) && $past(r_frame_rdy))
        else $error("fetch without accepted pull");

endmodule

### test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        xcpf_pkg::t_op     op;
        logic [7:0]        data;
        logic              last;
    } t_request;

    typedef struct {
        xcpf_pkg::t_status status;
        logic [7:0]        pkt_byte;
        logic              eop;
    } t_reply;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [xcpf_pkg::APB_AW-1:0] paddr;
    logic [xcpf_pkg::APB_DW-1:0] pwdata;
    logic [xcpf_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    xcpf_req_if req ();
    xcpf_rsp_if rsp ();

    xor_checked_packet_framer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_request request_backlog[$];
    t_reply   awaited_replies[$];
    t_request on_wire;
    int       err_count = 0;

    // shadow of the framer
    logic [7:0] tag_reg = 8'h00;
    logic [7:0] pad_reg = 8'h00;
    logic [7:0] payload_mem [xcpf_pkg::MAX_PAYLOAD];
    int         pay_count = 0;
    logic [7:0] xor_sum = 8'h00;
    int         frame_len = 0;
    int         emit_pos = 0;
    bit         frame_pending = 1'b0;

    // stream generator position
    int gen_fill = 0;
    int gen_left = 0;
    int gen_target = 0;

    int send_wait = 0;
    int send_run = 0;
    bit send_calm = 1'b0;
    int recv_wait = 0;
    int recv_run = 0;
    bit recv_calm = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int frame_size(int n);
        int base;
        base = n + xcpf_pkg::HEADER_BYTES + xcpf_pkg::FOOTER_BYTES;
        return (pad_reg == 8'h00) ? base : (base / int'(pad_reg) + 1) * int'(pad_reg);
    endfunction

    function automatic t_reply predict_framer_reply(t_request r);
        t_reply res;
        res.status   = xcpf_pkg::ST_ACCEPTED;
        res.pkt_byte = 8'h00;
        res.eop      = 1'b0;
        if (r.op == xcpf_pkg::OP_PUSH) begin
            if (frame_pending || pay_count >= xcpf_pkg::MAX_PAYLOAD) begin
                res.status = xcpf_pkg::ST_REFUSED;
            end else begin
                payload_mem[pay_count] = r.data;
                xor_sum = xor_sum ^ r.data;
                pay_count++;
                if (r.last) begin
                    frame_len     = frame_size(pay_count);
                    emit_pos      = 0;
                    frame_pending = 1'b1;
                end
            end
        end else if (!frame_pending) begin
            res.status = xcpf_pkg::ST_EMPTY;
        end else begin
            res.status = xcpf_pkg::ST_EMITTED;
            if (emit_pos == frame_len - 1)
                res.pkt_byte = xcpf_pkg::NEWLINE_BYTE;
            else if (emit_pos < xcpf_pkg::SYNC_END)
                res.pkt_byte = xcpf_pkg::SYNC_BYTE;
            else if (emit_pos < xcpf_pkg::PKT_SIZE_END)
                res.pkt_byte = 8'(frame_len >> (8 * (emit_pos - xcpf_pkg::SYNC_END)));
            else if (emit_pos < xcpf_pkg::PAY_SIZE_END)
                res.pkt_byte = 8'(pay_count >> (8 * (emit_pos - xcpf_pkg::PKT_SIZE_END)));
            else if (emit_pos == xcpf_pkg::TAG_POS)
                res.pkt_byte = tag_reg;
            else if (emit_pos == xcpf_pkg::XOR_POS)
                res.pkt_byte = xor_sum;
            else if (emit_pos - xcpf_pkg::HEADER_BYTES < pay_count)
                res.pkt_byte = payload_mem[emit_pos - xcpf_pkg::HEADER_BYTES];
            else
                res.pkt_byte = xcpf_pkg::PAD_BYTE;
            if (emit_pos == frame_len - 1) begin
                res.eop       = 1'b1;
                frame_pending = 1'b0;
                pay_count     = 0;
                xor_sum       = 8'h00;
                emit_pos      = 0;
            end else begin
                emit_pos++;
            end
        end
        return res;
    endfunction

    // idle cycles per request or reply, in runs that are either busy or gap-free
    function automatic int draw_gap(inout int run_left, inout bit calm);
        if (run_left == 0) begin
            run_left = $urandom_range(10, 60);
            calm     = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic void flag(string what, int want, int got);
        err_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req.valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (req.valid && req.ready === 1'b1)
                awaited_replies.push_back(predict_framer_reply(on_wire));
            if (!req.valid || req.ready === 1'b1) begin
                if (send_wait > 0) begin
                    send_wait--;
                    req.valid <= 1'b0;
                end else if (request_backlog.size() != 0) begin
                    on_wire = request_backlog.pop_front();
                    req.valid        <= 1'b1;
                    req.operation    <= on_wire.op;
                    req.payload_byte <= on_wire.data;
                    req.payload_last <= on_wire.last;
                    send_wait = draw_gap(send_run, send_calm);
                end else begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_reply want;
        int     n;
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
            recv_wait = 0;
        end else if (rsp.valid === 1'b1 && rsp.ready) begin
            if (awaited_replies.size() == 0) begin
                err_count++;
                $display("%0t: reply with nothing outstanding, expected none, actual %0d/%0d/%0d",
                         $time, rsp.status, rsp.packet_byte, rsp.end_of_packet);
            end else begin
                want = awaited_replies.pop_front();
                if (rsp.status !== want.status)
                    flag("status", want.status, rsp.status);
                if (rsp.packet_byte !== want.pkt_byte)
                    flag("packet_byte", want.pkt_byte, rsp.packet_byte);
                if (rsp.end_of_packet !== want.eop)
                    flag("end_of_packet", want.eop, rsp.end_of_packet);
            end
            n = draw_gap(recv_run, recv_calm);
            if (n != 0) begin
                rsp.ready <= 1'b0;
                recv_wait = n;
            end
        end else if (!rsp.ready) begin
            if (recv_wait <= 1)
                rsp.ready <= 1'b1;
            if (recv_wait > 0)
                recv_wait--;
        end
    end

    function automatic void queue_request(xcpf_pkg::t_op op, logic [7:0] data, logic last);
        request_backlog.push_back(t_request'{op, data, last});
    endfunction

    task automatic apb_write(xcpf_pkg::t_reg idx, logic [7:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= xcpf_pkg::APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == xcpf_pkg::REG_TAG)
            tag_reg = value;
        else
            pad_reg = value;
    endtask

    function automatic logic [7:0] pick_value();
        case ($urandom_range(0, 4))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h01;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (request_backlog.size() != 0 || req.valid || awaited_replies.size() != 0);
    endtask

    // well-formed packets with random content, sprinkled with refused pushes and empty pulls
    task automatic stream(int count, bit to_clean);
        int k;
        k = 0;
        while (k < count || (to_clean && (gen_target != 0 || gen_left != 0))) begin
            if (gen_left > 0) begin
                if ($urandom_range(0, 11) == 0) begin
                    queue_request(xcpf_pkg::OP_PUSH, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
                end else begin
                    queue_request(xcpf_pkg::OP_PULL, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
                    gen_left--;
                end
            end else begin
                if (gen_target == 0)
                    gen_target = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300)
                                                              : $urandom_range(1, 40);
                if ($urandom_range(0, 11) == 0) begin
                    queue_request(xcpf_pkg::OP_PULL, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
                end else begin
                    gen_fill++;
                    queue_request(xcpf_pkg::OP_PUSH, 8'($urandom_range(0, 255)),
                                  gen_fill == gen_target);
                    if (gen_fill == gen_target) begin
                        gen_left   = frame_size(gen_fill);
                        gen_fill   = 0;
                        gen_target = 0;
                    end
                end
            end
            k++;
        end
    endtask

    initial begin
        int issued;
        int burst;
        i_rst_n          = 1'b0;
        req.valid        = 1'b0;
        req.operation    = xcpf_pkg::OP_PUSH;
        req.payload_byte = 8'h00;
        req.payload_last = 1'b0;
        rsp.ready        = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, registers at reset values
        queue_request(xcpf_pkg::OP_PULL, 8'hFF, 1'b1);
        queue_request(xcpf_pkg::OP_PUSH, 8'h00, 1'b0);
        queue_request(xcpf_pkg::OP_PULL, 8'h00, 1'b0);
        queue_request(xcpf_pkg::OP_PUSH, 8'hFF, 1'b1);
        queue_request(xcpf_pkg::OP_PUSH, 8'h5A, 1'b1);
        repeat (frame_size(2)) queue_request(xcpf_pkg::OP_PULL, 8'h00, 1'b0);
        queue_request(xcpf_pkg::OP_PULL, 8'hFF, 1'b1);
        wait_drained();

        issued = 0;
        while (issued < 800) begin
            if ($urandom_range(0, 1) == 0)
                apb_write(xcpf_pkg::REG_TAG, pick_value());
            if ($urandom_range(0, 1) == 0)
                apb_write(xcpf_pkg::REG_PAD, pick_value());
            burst = $urandom_range(20, 150);
            stream(burst, 1'b0);
            issued += burst;
            wait_drained();
        end
        stream(0, 1'b1);
        wait_drained();

        // fill the buffer without a last mark; every push after is refused, the pull finds no frame
        apb_write(xcpf_pkg::REG_TAG, 8'h00);
        apb_write(xcpf_pkg::REG_PAD, 8'h00);
        repeat (xcpf_pkg::MAX_PAYLOAD)
            queue_request(xcpf_pkg::OP_PUSH, 8'($urandom_range(0, 255)), 1'b0);
        queue_request(xcpf_pkg::OP_PUSH, 8'hFF, 1'b1);
        queue_request(xcpf_pkg::OP_PUSH, 8'h00, 1'b0);
        queue_request(xcpf_pkg::OP_PULL, 8'h00, 1'b0);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
